@@ sv/lfb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the LIN frame build and check block.
// No dependencies; lfb_engine, lfb_result_buf and the top level import it.
package lfb_pkg;

  localparam logic [3:0] MaxPayload = 4'd8;
  localparam logic [7:0] SyncByte   = 8'h55;
  localparam int unsigned MaxResults = 4;

  typedef enum logic {
    OpTx = 1'b0,
    OpRx = 1'b1
  } lfb_op_e;

  typedef enum logic {
    KindTxByte  = 1'b0,
    KindVerdict = 1'b1
  } lfb_kind_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusPidBad    = 2'd1,
    StatusChkBad    = 2'd2,
    StatusLengthBad = 2'd3
  } lfb_status_e;

  typedef struct packed {
    logic       op;
    logic [5:0] frame_id;
    logic [7:0] data_byte;
    logic [3:0] payload_length;
    logic       first_byte;
    logic       last_byte;
  } lfb_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [1:0] frame_status;
    logic       end_of_frame;
  } lfb_res_t;

  typedef struct packed {
    logic [2:0]                count;
    lfb_res_t [MaxResults-1:0] res;
  } lfb_batch_t;

  function automatic logic [7:0] lfb_protect_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  function automatic logic [7:0] lfb_carry_add(input logic [7:0] sum, input logic [7:0] d);
    logic [8:0] t;
    t = {1'b0, sum} + {1'b0, d};
    return t[8] ? (t[7:0] + 8'd1) : t[7:0];
  endfunction

endpackage

@@ sv/lfb_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and result items.
// No dependencies.
interface lfb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [5:0] frame_id;
  logic [7:0] data_byte;
  logic [3:0] payload_length;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output op, output frame_id, output data_byte,
                  output payload_length, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input op, input frame_id, input data_byte,
                input payload_length, input first_byte, input last_byte,
                output ready);
endinterface

interface lfb_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic [1:0] frame_status;
  logic       end_of_run;
  logic       end_of_frame;

  modport source (output valid, output kind, output out_byte, output frame_status,
                  output end_of_run, output end_of_frame, input ready);
  modport sink (input valid, input kind, input out_byte, input frame_status,
                input end_of_run, input end_of_frame, output ready);
endinterface

@@ sv/lfb_engine.sv @@
`timescale 1ns / 1ps
// Frame state and per-item logic: builds the batch of results for one item.
// Depends on lfb_pkg.
module lfb_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfb_pkg::lfb_item_t item_i,
  input  logic              fire_i,
  output lfb_pkg::lfb_batch_t batch_o
);
  import lfb_pkg::*;

  logic [3:0] tx_count_q, tx_count_d;
  logic [3:0] tx_length_q, tx_length_d;
  logic [7:0] tx_sum_q, tx_sum_d;
  logic       tx_dropping_q, tx_dropping_d;
  logic [3:0] rx_count_q, rx_count_d;
  logic [7:0] rx_sum_q, rx_sum_d;
  logic       rx_pid_bad_q, rx_pid_bad_d;
  logic [7:0] rx_last_byte_q, rx_last_byte_d;

  always_comb begin
    lfb_batch_t  b;
    logic [2:0]  n;
    logic [7:0]  pid;
    logic [7:0]  s;
    logic [3:0]  c;
    logic [3:0]  idx;
    lfb_status_e st;
    b = '0;
    n = 3'd0;
    pid = lfb_protect_id(item_i.frame_id);
    s = 8'd0;
    c = 4'd0;
    idx = 4'd0;
    st = StatusOk;
    tx_count_d = tx_count_q;
    tx_length_d = tx_length_q;
    tx_sum_d = tx_sum_q;
    tx_dropping_d = tx_dropping_q;
    rx_count_d = rx_count_q;
    rx_sum_d = rx_sum_q;
    rx_pid_bad_d = rx_pid_bad_q;
    rx_last_byte_d = rx_last_byte_q;

    if (item_i.op == OpTx) begin
      if (item_i.first_byte) begin
        tx_count_d = 4'd0;
        tx_length_d = 4'd0;
        tx_sum_d = 8'd0;
        tx_dropping_d = 1'b0;
        if (item_i.payload_length > MaxPayload) begin
          tx_dropping_d = 1'b1;
        end else begin
          tx_length_d = item_i.payload_length;
          tx_sum_d = pid;
          b.res[0] = '{kind: KindTxByte, out_byte: SyncByte, frame_status: StatusOk,
                       end_of_frame: 1'b0};
          b.res[1] = '{kind: KindTxByte, out_byte: pid, frame_status: StatusOk,
                       end_of_frame: 1'b0};
          n = 3'd2;
          if (item_i.payload_length == 4'd0) begin
            b.res[2] = '{kind: KindTxByte, out_byte: ~pid, frame_status: StatusOk,
                         end_of_frame: 1'b1};
            n = 3'd3;
          end else begin
            s = lfb_carry_add(pid, item_i.data_byte);
            b.res[2] = '{kind: KindTxByte, out_byte: item_i.data_byte,
                         frame_status: StatusOk, end_of_frame: 1'b0};
            n = 3'd3;
            tx_sum_d = s;
            tx_count_d = 4'd1;
            if (item_i.payload_length == 4'd1) begin
              b.res[3] = '{kind: KindTxByte, out_byte: ~s, frame_status: StatusOk,
                           end_of_frame: 1'b1};
              n = 3'd4;
            end
          end
        end
      end else if (!tx_dropping_q && (tx_count_q < tx_length_q)) begin
        s = lfb_carry_add(tx_sum_q, item_i.data_byte);
        c = tx_count_q + 4'd1;
        b.res[0] = '{kind: KindTxByte, out_byte: item_i.data_byte, frame_status: StatusOk,
                     end_of_frame: 1'b0};
        n = 3'd1;
        tx_sum_d = s;
        tx_count_d = c;
        if (c >= tx_length_q) begin
          b.res[1] = '{kind: KindTxByte, out_byte: ~s, frame_status: StatusOk,
                       end_of_frame: 1'b1};
          n = 3'd2;
        end
      end
    end else begin
      if (item_i.first_byte) begin
        rx_count_d = 4'd0;
        rx_sum_d = 8'd0;
        rx_pid_bad_d = 1'b0;
        rx_last_byte_d = 8'd0;
      end
      idx = rx_count_d;
      if (idx == 4'd1) begin
        rx_sum_d = item_i.data_byte;
        rx_pid_bad_d = (item_i.data_byte != pid);
      end else if (idx >= 4'd3) begin
        rx_sum_d = lfb_carry_add(rx_sum_d, rx_last_byte_d);
      end
      if (!item_i.last_byte) begin
        if (idx >= 4'd2) begin
          rx_last_byte_d = item_i.data_byte;
        end
        if (idx != 4'd15) begin
          rx_count_d = idx + 4'd1;
        end
      end else begin
        if ((item_i.payload_length > MaxPayload) ||
            (({1'b0, idx} + 5'd1) != ({1'b0, item_i.payload_length} + 5'd3))) begin
          st = StatusLengthBad;
        end else if (rx_pid_bad_d) begin
          st = StatusPidBad;
        end else if (~rx_sum_d != item_i.data_byte) begin
          st = StatusChkBad;
        end else begin
          st = StatusOk;
        end
        b.res[0] = '{kind: KindVerdict, out_byte: 8'd0, frame_status: st,
                     end_of_frame: 1'b1};
        n = 3'd1;
        rx_count_d = 4'd0;
        rx_sum_d = 8'd0;
        rx_pid_bad_d = 1'b0;
        rx_last_byte_d = 8'd0;
      end
    end
    b.count = n;
    batch_o = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_count_q <= '0;
      tx_length_q <= '0;
      tx_sum_q <= '0;
      tx_dropping_q <= 1'b0;
      rx_count_q <= '0;
      rx_sum_q <= '0;
      rx_pid_bad_q <= 1'b0;
      rx_last_byte_q <= '0;
    end else if (fire_i) begin
      tx_count_q <= tx_count_d;
      tx_length_q <= tx_length_d;
      tx_sum_q <= tx_sum_d;
      tx_dropping_q <= tx_dropping_d;
      rx_count_q <= rx_count_d;
      rx_sum_q <= rx_sum_d;
      rx_pid_bad_q <= rx_pid_bad_d;
      rx_last_byte_q <= rx_last_byte_d;
    end
  end

endmodule

@@ sv/lfb_result_buf.sv @@
`timescale 1ns / 1ps
// Result register: holds one batch of results and hands them out one per cycle while the output is ready.
// Depends on lfb_pkg and lfb_out_if.
module lfb_result_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfb_pkg::lfb_batch_t batch_i,
  input  logic                load_i,
  output logic                load_ok_o,
  lfb_out_if.source           out_o
);
  import lfb_pkg::*;

  lfb_res_t [MaxResults-1:0] res_q;
  logic [2:0]                left_q;
  logic                      pop;

  assign pop = out_o.valid && out_o.ready;
  assign load_ok_o = (left_q == 3'd0) || ((left_q == 3'd1) && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
    end else if (load_i) begin
      left_q <= batch_i.count;
    end else if (pop) begin
      left_q <= left_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= batch_i.res;
    end else if (pop) begin
      res_q <= {lfb_res_t'('0), res_q[MaxResults-1:1]};
    end
  end

  assign out_o.valid        = (left_q != 3'd0);
  assign out_o.kind         = res_q[0].kind;
  assign out_o.out_byte     = res_q[0].out_byte;
  assign out_o.frame_status = res_q[0].frame_status;
  assign out_o.end_of_frame = res_q[0].end_of_frame;
  assign out_o.end_of_run   = (left_q == 3'd1);

endmodule

@@ sv/lin_frame_build_and_check.sv @@
`timescale 1ns / 1ps
// Top level of the LIN frame build and check block: input register, engine, result buffer.
// Depends on lfb_pkg, lfb_if, lfb_engine and lfb_result_buf.

// LIN frame engine with enhanced checksum. Transmit items (op 0) emit sync, protected id,
// data and inverted checksum bytes; receive items (op 1) give one verdict on the item
// marked last. Frames with payload_length above 8 are dropped (transmit) or reported as
// wrong length (receive). Each item passes through an input register and is worked out
// combinationally into a result buffer that drives the output one result per cycle while
// the output is ready. An item causes n (0 to 4) results, and the next item is loaded as
// the last of them leaves, so the single output port draining the buffer sets the pace.
// An item reaches the result buffer through the input register; results leave the buffer.
module lin_frame_build_and_check (
  input  logic clk_i,
  input  logic rst_ni,
  lfb_in_if.sink    in_i,
  lfb_out_if.source out_o
);
  import lfb_pkg::*;

  lfb_item_t  item_q;
  logic       item_vld_q;
  logic       load_ok;
  logic       take;
  lfb_batch_t batch;

  assign take = item_vld_q && load_ok;
  assign in_i.ready = !item_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= '{op: in_i.op, frame_id: in_i.frame_id, data_byte: in_i.data_byte,
                  payload_length: in_i.payload_length, first_byte: in_i.first_byte,
                  last_byte: in_i.last_byte};
    end
  end

  lfb_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .fire_i  (take),
    .batch_o (batch)
  );

  lfb_result_buf u_result_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .batch_i   (batch),
    .load_i    (take),
    .load_ok_o (load_ok),
    .out_o     (out_o)
  );

endmodule
